// ===== hw/rtl/ntcm_pkg.sv =====
// Shared constants and types for the nearest tile colour match block.
// Used by the channel interfaces and every module under hw/rtl but ntcm_tile_mem.
`timescale 1ns / 1ps
`default_nettype none

package ntcm_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned OpW       = 1;
  localparam int unsigned TileIdxW  = 6;
  localparam int unsigned ChanInW   = 16;
  localparam int unsigned BestTileW = 6;
  localparam int unsigned BestDistW = 18;

  // Configuration register and APB port.
  localparam int unsigned TileCntW   = 7;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic [TileCntW-1:0] TileCountReset = 7'd1;

  // Register index, taken from the word address bit of paddr.
  localparam logic RegTileCount = 1'b0;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxTilesDef    = 64;
  localparam int unsigned ChannelBitsDef = 16;

  // Operation codes carried by an input transaction.
  typedef enum logic [OpW-1:0] {
    OpLoad  = 1'b0,
    OpMatch = 1'b1
  } ntcm_op_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ntcm_if.sv =====
// Valid/ready channel interfaces for the input items and the match results.
// Field widths come from ntcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ntcm_item_if;
  logic                         valid;
  logic                         ready;
  logic [ntcm_pkg::OpW-1:0]     operation;
  logic [ntcm_pkg::TileIdxW-1:0] tile_index;
  logic [ntcm_pkg::ChanInW-1:0] red;
  logic [ntcm_pkg::ChanInW-1:0] green;
  logic [ntcm_pkg::ChanInW-1:0] blue;

  modport source (output valid, output operation, output tile_index, output red,
                  output green, output blue, input ready);
  modport sink (input valid, input operation, input tile_index, input red,
                input green, input blue, output ready);
endinterface

interface ntcm_result_if;
  logic                           valid;
  logic                           ready;
  logic [ntcm_pkg::BestTileW-1:0] best_tile;
  logic [ntcm_pkg::BestDistW-1:0] best_distance;

  modport source (output valid, output best_tile, output best_distance, input ready);
  modport sink (input valid, input best_tile, input best_distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ntcm_cfg_regs.sv =====
// APB register block holding the tile_count configuration register.
// Depends on ntcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntcm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ntcm_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [ntcm_pkg::ApbDataW-1:0] pwdata,
  output      logic [ntcm_pkg::ApbDataW-1:0] prdata,
  output      logic                          pready,
  output      logic [ntcm_pkg::TileCntW-1:0] tile_count_o
);

  logic                          wr_tile_count;
  logic [ntcm_pkg::TileCntW-1:0] tile_count_d, tile_count_q;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // A write completes in the access phase; only the register word is decoded.
  assign wr_tile_count = psel & penable & pwrite &
                         (paddr[ntcm_pkg::ApbAddrW-1] == ntcm_pkg::RegTileCount);

  always_comb begin
    tile_count_d = tile_count_q;
    if (wr_tile_count) begin
      tile_count_d = pwdata[ntcm_pkg::TileCntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_count_q <= ntcm_pkg::TileCountReset;
    end else begin
      tile_count_q <= tile_count_d;
    end
  end

  // Read data; addresses past the register list read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[ntcm_pkg::ApbAddrW-1] == ntcm_pkg::RegTileCount) begin
      prdata = ntcm_pkg::ApbDataW'(tile_count_q);
    end
  end

  assign tile_count_o = tile_count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ntcm_tile_mem.sv =====
// Tile colour table: one write port and one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ntcm_tile_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Entries hold garbage until loaded; no clearing is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ntcm_search.sv =====
// Transaction control and the scan pipeline: loads write the tile table, a match
// walks the table one entry per cycle and keeps the closest tile by L1 distance.
// Depends on ntcm_pkg and ntcm_if.
`timescale 1ns / 1ps
`default_nettype none

module ntcm_search #(
  parameter int unsigned MaxTiles    = ntcm_pkg::MaxTilesDef,
  parameter int unsigned ChannelBits = ntcm_pkg::ChannelBitsDef,
  localparam int unsigned AddrW = (MaxTiles > 1) ? $clog2(MaxTiles) : 1,
  localparam int unsigned MemW  = 3 * ChannelBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ntcm_item_if.sink                          item_i,
  ntcm_result_if.source                      result_o,
  input  wire logic [ntcm_pkg::TileCntW-1:0] tile_count_i,
  output      logic                          mem_wr_en_o,
  output      logic [AddrW-1:0]              mem_wr_addr_o,
  output      logic [MemW-1:0]               mem_wr_data_o,
  output      logic                          mem_rd_en_o,
  output      logic [AddrW-1:0]              mem_rd_addr_o,
  input  wire logic [MemW-1:0]               mem_rd_data_i
);

  localparam int unsigned DistW  = ChannelBits + 2;
  localparam int unsigned LimW   = $clog2(MaxTiles + 1);
  localparam int unsigned CmpW   = (LimW > ntcm_pkg::TileCntW) ? LimW : ntcm_pkg::TileCntW;
  localparam int unsigned IdxCmpW = (CmpW > ntcm_pkg::TileIdxW) ? CmpW : ntcm_pkg::TileIdxW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } ntcm_state_e;

  ntcm_state_e state_d, state_q;

  logic item_accept, item_load, item_match;
  logic [CmpW-1:0] count_ext, count_clamped;
  logic [AddrW-1:0] last_d;

  // Scan control: read issue, read data valid, distance valid.
  logic             issue_d, issue_q;
  logic [AddrW-1:0] addr_d, addr_q;
  logic [AddrW-1:0] last_q;
  logic             rd_vld_d, rd_vld_q;
  logic [AddrW-1:0] rd_idx_q;
  logic             dist_vld_d, dist_vld_q;
  logic [AddrW-1:0] dist_idx_q;
  logic             dist_last_q;
  logic [DistW-1:0] dist_q, dist_calc;
  logic [DistW-1:0] best_dist_q;
  logic [AddrW-1:0] best_idx_q;
  logic             best_take;

  // Cell colour held for the whole scan, channels masked to ChannelBits.
  logic [ChannelBits-1:0] cell_q [3];

  // Output register.
  logic                           out_vld_d, out_vld_q;
  logic                           out_load;
  logic [ntcm_pkg::BestTileW-1:0] out_tile_q;
  logic [ntcm_pkg::BestDistW-1:0] out_dist_q;

  // New transactions are taken only between scans.
  assign item_i.ready = (state_q == StIdle);
  assign item_accept  = item_i.valid & item_i.ready;
  assign item_load    = item_accept & (item_i.operation == ntcm_pkg::OpLoad);
  assign item_match   = item_accept & (item_i.operation == ntcm_pkg::OpMatch);

  // Table write for a load; indexes past the table are dropped.
  assign mem_wr_en_o   = item_load &
                         (IdxCmpW'(item_i.tile_index) < IdxCmpW'(MaxTiles));
  assign mem_wr_addr_o = AddrW'(item_i.tile_index);
  assign mem_wr_data_o = {item_i.red[ChannelBits-1:0], item_i.green[ChannelBits-1:0],
                          item_i.blue[ChannelBits-1:0]};

  // Number of entries searched: zero counts as one, large values saturate.
  always_comb begin
    count_ext     = CmpW'(tile_count_i);
    count_clamped = count_ext;
    if (count_ext == '0) begin
      count_clamped = CmpW'(1);
    end else if (count_ext > CmpW'(MaxTiles)) begin
      count_clamped = CmpW'(MaxTiles);
    end
  end
  assign last_d = AddrW'(count_clamped - CmpW'(1));

  // Read issue: one table address per cycle from entry zero to the last one.
  assign mem_rd_en_o   = issue_q;
  assign mem_rd_addr_o = addr_q;

  always_comb begin
    issue_d  = issue_q;
    addr_d   = addr_q;
    rd_vld_d = 1'b0;
    if (item_match) begin
      issue_d = 1'b1;
      addr_d  = '0;
    end else if (issue_q) begin
      rd_vld_d = 1'b1;
      if (addr_q == last_q) begin
        issue_d = 1'b0;
      end else begin
        addr_d = addr_q + AddrW'(1);
      end
    end
  end

  // L1 distance between the cell and the entry just read.
  always_comb begin
    logic [ChannelBits-1:0] tile_ch;
    logic [ChannelBits-1:0] diff [3];
    dist_calc = '0;
    for (int c = 0; c < 3; c++) begin
      tile_ch = mem_rd_data_i[(2 - c) * ChannelBits +: ChannelBits];
      diff[c] = (cell_q[c] > tile_ch) ? (cell_q[c] - tile_ch) : (tile_ch - cell_q[c]);
      dist_calc = dist_calc + DistW'(diff[c]);
    end
  end

  assign dist_vld_d = rd_vld_q;

  // Strict less-than keeps the lowest index on ties; entry zero always seeds.
  assign best_take = dist_vld_q & ((dist_idx_q == '0) | (dist_q < best_dist_q));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (item_match) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (dist_vld_q && dist_last_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || result_o.ready) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The result moves to the output register once that register is free.
  assign out_load = (state_q == StDone) & (~out_vld_q | result_o.ready);

  always_comb begin
    out_vld_d = out_vld_q & ~result_o.ready;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      issue_q    <= 1'b0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      dist_vld_q <= dist_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers of the scan pipeline and the output.
  always_ff @(posedge clk_i) begin
    if (item_match) begin
      last_q    <= last_d;
      cell_q[0] <= item_i.red[ChannelBits-1:0];
      cell_q[1] <= item_i.green[ChannelBits-1:0];
      cell_q[2] <= item_i.blue[ChannelBits-1:0];
    end
    if (issue_q) begin
      rd_idx_q <= addr_q;
    end
    if (rd_vld_q) begin
      dist_q      <= dist_calc;
      dist_idx_q  <= rd_idx_q;
      dist_last_q <= (rd_idx_q == last_q);
    end
    if (best_take) begin
      best_dist_q <= dist_q;
      best_idx_q  <= dist_idx_q;
    end
    if (out_load) begin
      out_tile_q <= ntcm_pkg::BestTileW'(best_idx_q);
      out_dist_q <= ntcm_pkg::BestDistW'(best_dist_q);
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.best_tile     = out_tile_q;
  assign result_o.best_distance = out_dist_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_tile_colour_match.sv =====
// Top level of the nearest tile colour match block: APB registers, tile table
// and scan engine. Depends on ntcm_pkg, ntcm_if and the ntcm_* modules.
//
//  Channel   Direction  Carries
//  item_i    in         operation, tile_index, red, green, blue (load or match)
//  result_o  out        best_tile, best_distance (one per match)
//  APB       in/out     tile_count register at byte address 0
//
// A load only writes the tile table and leaves the block idle. A match reads
// the table once per entry of the clamped tile_count through its single read
// port; the next item is taken once the result is in the output register.
// A finished result waits in the output register while new items are taken.
// Reset sets tile_count to 1; the table is not cleared, entries are valid
// once loaded.
`timescale 1ns / 1ps
`default_nettype none

module nearest_tile_colour_match #(
  parameter int unsigned MaxTiles    = ntcm_pkg::MaxTilesDef,
  parameter int unsigned ChannelBits = ntcm_pkg::ChannelBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ntcm_item_if.sink                          item_i,
  ntcm_result_if.source                      result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ntcm_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [ntcm_pkg::ApbDataW-1:0] pwdata,
  output      logic [ntcm_pkg::ApbDataW-1:0] prdata,
  output      logic                          pready
);

  localparam int unsigned AddrW = (MaxTiles > 1) ? $clog2(MaxTiles) : 1;
  localparam int unsigned MemW  = 3 * ChannelBits;

  logic [ntcm_pkg::TileCntW-1:0] tile_count;
  logic                          mem_wr_en, mem_rd_en;
  logic [AddrW-1:0]              mem_wr_addr, mem_rd_addr;
  logic [MemW-1:0]               mem_wr_data, mem_rd_data;

  // Configuration registers.
  ntcm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tile_count_o(tile_count)
  );

  // Tile colour table.
  ntcm_tile_mem #(
    .Depth(MaxTiles),
    .Width(MemW)
  ) u_tile_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  // Transaction handling and the search pipeline.
  ntcm_search #(
    .MaxTiles   (MaxTiles),
    .ChannelBits(ChannelBits)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .result_o     (result_o),
    .tile_count_i (tile_count),
    .mem_wr_en_o  (mem_wr_en),
    .mem_wr_addr_o(mem_wr_addr),
    .mem_wr_data_o(mem_wr_data),
    .mem_rd_en_o  (mem_rd_en),
    .mem_rd_addr_o(mem_rd_addr),
    .mem_rd_data_i(mem_rd_data)
  );

endmodule

`default_nettype wire

// ===== test/nearest_tile_colour_match_tb.sv =====
// Self-checking testbench for nearest_tile_colour_match: directed and random
// load/match traffic over the valid/ready channels and the APB register.
// Depends on ntcm_pkg, ntcm_if and the RTL under hw/rtl.
`timescale 1ns / 1ps

module nearest_tile_colour_match_tb;
  import ntcm_pkg::*;

  localparam int unsigned TableDepth  = MaxTilesDef;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned RandomItems = 140;
  localparam logic [ApbAddrW-1:0] TileCountAddr = {RegTileCount, 2'b00};

  typedef struct packed {
    logic [BestTileW-1:0] best_tile;
    logic [BestDistW-1:0] best_distance;
  } match_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ntcm_item_if   item_bus ();
  ntcm_result_if result_bus ();

  nearest_tile_colour_match u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: our own copy of the tile table and the count register.
  logic [ChanInW-1:0]  tile_red   [TableDepth];
  logic [ChanInW-1:0]  tile_green [TableDepth];
  logic [ChanInW-1:0]  tile_blue  [TableDepth];
  logic [TileCntW-1:0] tile_count_cfg = TileCountReset;

  match_result_t expected_matches [$];
  int unsigned   failure_count = 0;
  bit            no_gaps = 1'b0;
  bit            hold_request = 1'b0;

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Known values on every block input from time zero.
  initial begin
    item_bus.valid      <= 1'b0;
    item_bus.operation  <= OpLoad;
    item_bus.tile_index <= '0;
    item_bus.red        <= '0;
    item_bus.green      <= '0;
    item_bus.blue       <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
  end

  // Search window after the count register is clamped to the table.
  function automatic int unsigned effective_count();
    int unsigned n;
    n = tile_count_cfg;
    if (n == 0) n = 1;
    if (n > TableDepth) n = TableDepth;
    return n;
  endfunction

  // L1 nearest-colour search over the active entries; strict less-than keeps
  // the lowest index on a tie.
  function automatic match_result_t nearest_tile(input logic [ChanInW-1:0] r,
                                                 input logic [ChanInW-1:0] g,
                                                 input logic [ChanInW-1:0] b);
    match_result_t   best;
    int unsigned     n;
    int unsigned     dr;
    int unsigned     dg;
    int unsigned     db;
    logic [BestDistW-1:0] d;
    n = effective_count();
    best.best_tile     = '0;
    best.best_distance = '1;
    for (int unsigned i = 0; i < n; i++) begin
      dr = (r > tile_red[i])   ? r - tile_red[i]   : tile_red[i] - r;
      dg = (g > tile_green[i]) ? g - tile_green[i] : tile_green[i] - g;
      db = (b > tile_blue[i])  ? b - tile_blue[i]  : tile_blue[i] - b;
      d  = BestDistW'(dr + dg + db);
      if (d < best.best_distance) begin
        best.best_distance = d;
        best.best_tile     = BestTileW'(i);
      end
    end
    return best;
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (no_gaps) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [ChanInW-1:0] random_channel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ChanInW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [ChanInW-1:0] near_channel(input logic [ChanInW-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return ChanInW'(v);
  endfunction

  task automatic note_failure(input string msg);
    failure_count++;
    if (failure_count <= ReportLimit) $display("mismatch: %s", msg);
  endtask

  // Offers one transaction and updates the predictor once it is accepted.
  task automatic send_item(input ntcm_op_e op, input logic [TileIdxW-1:0] idx,
                           input logic [ChanInW-1:0] r, input logic [ChanInW-1:0] g,
                           input logic [ChanInW-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.operation  <= op;
    item_bus.tile_index <= idx;
    item_bus.red        <= r;
    item_bus.green      <= g;
    item_bus.blue       <= b;
    do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
    if (op == OpLoad) begin
      tile_red[idx]   = r;
      tile_green[idx] = g;
      tile_blue[idx]  = b;
    end else begin
      expected_matches.insert(expected_matches.size(), nearest_tile(r, g, b));
    end
  endtask

  // Stops offering items and waits until every match has come back.
  task automatic drain_block(input int unsigned extra);
    item_bus.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB write of the tile count, only while the block is idle.
  task automatic write_tile_count(input logic [TileCntW-1:0] value);
    drain_block(SettleCycles);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TileCountAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tile_count_cfg = value;
  endtask

  // Result side: checks each transaction and drives ready with random
  // stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned   stall;
    match_result_t exp;
    stall = 0;
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        if (expected_matches.size() == 0) begin
          note_failure($sformatf("unexpected result tile %0d distance %0d",
                                 result_bus.best_tile, result_bus.best_distance));
        end else begin
          exp = expected_matches.pop_front();
          if (result_bus.best_tile !== exp.best_tile)
            note_failure($sformatf("best_tile expected %0d got %0d",
                                   exp.best_tile, result_bus.best_tile));
          if (result_bus.best_distance !== exp.best_distance)
            note_failure($sformatf("best_distance expected %0d got %0d",
                                   exp.best_distance, result_bus.best_distance));
        end
        if (stall == 0) stall = pick_gap();
      end else if (stall == 0 && $urandom_range(0, 15) == 0) begin
        stall = pick_gap();
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HoldCycles;
      end
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        stall--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Reset count of one: only entry 0 takes part, even at the distance extremes.
  task automatic test_reset_count;
    send_item(OpLoad, 6'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OpMatch, 6'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OpMatch, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OpLoad, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OpMatch, 6'd21, 16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // One pure channel per entry, exact hits, ties and duplicated entries.
  task automatic test_nearest_and_ties;
    write_tile_count(7'd4);
    send_item(OpLoad, 6'd1, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(OpLoad, 6'd2, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(OpLoad, 6'd3, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(OpMatch, 6'd42, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(OpMatch, 6'd0, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(OpMatch, 6'd0, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(OpMatch, 6'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(OpMatch, 6'd0, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(OpLoad, 6'd3, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(OpMatch, 6'd0, 16'hFFFF, 16'h0000, 16'h0000);
  endtask

  // A count of zero behaves as a count of one.
  task automatic test_zero_count;
    write_tile_count(7'd0);
    send_item(OpMatch, 6'd0, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(OpMatch, 6'd0, 16'h1234, 16'h5678, 16'h9ABC);
  endtask

  // Fills every entry so that any count can be searched afterwards.
  task automatic test_load_full_table;
    for (int unsigned i = 0; i < TableDepth; i++)
      send_item(OpLoad, TileIdxW'(i), random_channel(), random_channel(), random_channel());
  endtask

  // A count above the table size saturates to the whole table.
  task automatic test_oversized_count;
    write_tile_count(7'd127);
    send_item(OpMatch, 6'd0, tile_red[63], tile_green[63], tile_blue[63]);
    send_item(OpMatch, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_tile_count(7'd64);
    send_item(OpMatch, 6'd0, tile_red[63], tile_green[63], tile_blue[63]);
  endtask

  // Results are held off for a long stretch while matches keep coming.
  task automatic test_result_backpressure;
    int unsigned k;
    write_tile_count(7'd4);
    no_gaps = 1'b1;
    hold_request = 1'b1;
    repeat (12) begin
      k = $urandom_range(0, 3);
      send_item(OpMatch, TileIdxW'($urandom), near_channel(tile_red[k]),
                near_channel(tile_green[k]), near_channel(tile_blue[k]));
    end
    no_gaps = 1'b0;
  endtask

  // Random loads and matches under one count setting.
  task automatic run_random_phase(input logic [TileCntW-1:0] count, input bit calm);
    int unsigned sel;
    int unsigned k;
    int unsigned n;
    write_tile_count(count);
    no_gaps = calm;
    n = effective_count();
    repeat (RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        // Loads sometimes copy another entry so that ties come up.
        k = $urandom_range(0, TableDepth - 1);
        if ($urandom_range(0, 2) == 0)
          send_item(OpLoad, TileIdxW'($urandom), tile_red[k], tile_green[k], tile_blue[k]);
        else
          send_item(OpLoad, TileIdxW'($urandom), random_channel(), random_channel(),
                    random_channel());
      end else if (sel < 70) begin
        k = $urandom_range(0, n - 1);
        send_item(OpMatch, TileIdxW'($urandom), near_channel(tile_red[k]),
                  near_channel(tile_green[k]), near_channel(tile_blue[k]));
      end else begin
        send_item(OpMatch, TileIdxW'($urandom), random_channel(), random_channel(),
                  random_channel());
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic;
    run_random_phase(7'd2, 1'b0);
    run_random_phase(7'd1, 1'b1);
    run_random_phase(7'd64, 1'b0);
    run_random_phase(7'd0, 1'b0);
    run_random_phase(7'd3, 1'b0);
    run_random_phase(7'd127, 1'b1);
    run_random_phase(7'd16, 1'b0);
    run_random_phase(7'd5, 1'b0);
    run_random_phase(7'd63, 1'b0);
    run_random_phase(7'd100, 1'b0);
    run_random_phase(7'd8, 1'b1);
    run_random_phase(7'd33, 1'b0);
    run_random_phase(TileCntW'($urandom_range(1, 64)), 1'b0);
    run_random_phase(TileCntW'($urandom_range(1, 64)), 1'b0);
  endtask

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin : main_sequence
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_count();
    test_nearest_and_ties();
    test_zero_count();
    test_load_full_table();
    test_oversized_count();
    test_result_backpressure();
    test_random_traffic();
    drain_block(DrainCycles);
    if (failure_count == 0 && expected_matches.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
